/* design/wtm_pkg.sv */
// Package for the whitespace-to-markup tab expander.
// Holds character codes, the command passed from front to back, and text tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wtm_pkg;

  localparam int CHAR_W       = 21;
  localparam int MAX_TAB_STOP = 16;
  localparam int REPS_W       = $clog2(MAX_TAB_STOP + 1);
  localparam int IDX_W        = 3;
  localparam int NBSP_LEN     = 6;
  localparam int BR_LEN       = 4;

  localparam logic [CHAR_W-1:0] CH_TAB   = 21'h00009;
  localparam logic [CHAR_W-1:0] CH_NL    = 21'h0000A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 21'h00020;
  localparam logic [CHAR_W-1:0] CH_LT    = 21'h0003C;
  localparam logic [CHAR_W-1:0] CH_GT    = 21'h0003E;

  typedef enum logic [1:0] {
    CMD_RAW,
    CMD_NBSP,
    CMD_BR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [CHAR_W-1:0]   ch;
    logic [REPS_W-1:0]   reps;
    logic                add_gt;
    logic                last;
  } cmd_t;

  function automatic logic [CHAR_W-1:0] nbsp_char(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      3'd0:    c = 21'h00026;
      3'd1:    c = 21'h0006E;
      3'd2:    c = 21'h00062;
      3'd3:    c = 21'h00073;
      3'd4:    c = 21'h00070;
      3'd5:    c = 21'h0003B;
      default: c = 21'h0003B;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] br_char(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      3'd0:    c = 21'h0003C;
      3'd1:    c = 21'h00062;
      3'd2:    c = 21'h00072;
      3'd3:    c = 21'h0003E;
      default: c = 21'h0003E;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/whitespace_to_markup_tab_expander.sv */
// Top level of the whitespace-to-markup tab expander: front end, queue, back end.
// Depends on wtm_pkg, wtm_front, wtm_queue, wtm_back.
//
//   channel | signals                                   | role
//   in      | in_valid in_ready char_code end_of_text   | one character per transaction
//   out     | out_valid out_ready out_char last_of_run   | one output character per
//           | text_done                                 | transaction
//
// The back end emits one character per cycle while out_ready is high; a plain
// character passes through, a newline becomes <br>, a space &nbsp; and a tab one
// &nbsp; per column to the next tab stop, plus '>' at end of text inside a tag.
// A two-entry command queue lets input run ahead of output; the input stalls
// only when the queue is full. An input reaches the output through its queue
// entry and then the back end's command register.
// Reset is synchronous; it clears the queue, tag flag and column.
`timescale 1ns / 1ps
`default_nettype none

module whitespace_to_markup_tab_expander
  import wtm_pkg::*;
#(
  parameter int TAB_STOP = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic              end_of_text,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   last_of_run,
  output logic                   text_done
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_not_empty;
  cmd_t q_head;

  wtm_front #(
    .TAB_STOP(TAB_STOP)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_code  (char_code),
    .end_of_text(end_of_text),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  wtm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  wtm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .last_of_run(last_of_run),
    .text_done  (text_done)
  );

endmodule

`default_nettype wire

/* design/wtm_front.sv */
// Front end: accepts characters, tracks tag and column state, issues commands.
// Depends on wtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtm_front
  import wtm_pkg::*;
#(
  parameter int TAB_STOP = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic              end_of_text,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              q_full,
  output logic                   push,
  output cmd_t                   push_cmd
);

  localparam int COL_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(TAB_STOP - 1);

  logic             inside_tag, inside_tag_next;
  logic [COL_W-1:0] column, column_next;
  logic [COL_W-1:0] column_adv;
  logic             tag_after;

  assign in_ready   = !q_full;
  assign push       = in_valid && in_ready;
  assign column_adv = (column == COL_LAST) ? '0 : column + COL_W'(1);

  always_comb begin
    push_cmd.kind = CMD_RAW;
    push_cmd.ch   = char_code;
    push_cmd.reps = REPS_W'(1);
    column_next   = column_adv;
    tag_after     = inside_tag;
    if (inside_tag) begin
      if (char_code == CH_GT) begin
        tag_after = 1'b0;
      end
    end else if (char_code == CH_LT) begin
      tag_after = 1'b1;
    end else if (char_code == CH_SPACE) begin
      push_cmd.kind = CMD_NBSP;
    end else if (char_code == CH_NL) begin
      push_cmd.kind = CMD_BR;
      column_next   = '0;
    end else if (char_code == CH_TAB) begin
      push_cmd.kind = CMD_NBSP;
      push_cmd.reps = REPS_W'(TAB_STOP) - REPS_W'(column);
      column_next   = '0;
    end
    push_cmd.add_gt = end_of_text && tag_after;
    push_cmd.last   = end_of_text;
    inside_tag_next = end_of_text ? 1'b0 : tag_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tag <= 1'b0;
      column     <= '0;
    end else if (push) begin
      inside_tag <= inside_tag_next;
      column     <= end_of_text ? '0 : column_next;
    end
  end

endmodule

`default_nettype wire

/* design/wtm_queue.sv */
// Two-entry command queue between front end and back end.
// Depends on wtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtm_queue
  import wtm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entry[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

/* design/wtm_back.sv */
// Back end: expands queued commands into output characters, one per cycle while out_ready is high.
// Depends on wtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtm_back
  import wtm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_not_empty,
  input  wire cmd_t              q_head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   last_of_run,
  output logic                   text_done
);

  cmd_t              cmd;
  logic              busy;
  logic [IDX_W-1:0]  idx;
  logic [REPS_W-1:0] rep;
  logic              gt_phase;
  logic              main_end;
  logic              final_char;
  logic              take;

  always_comb begin
    unique case (cmd.kind)
      CMD_RAW: begin
        main_end = 1'b1;
        out_char = cmd.ch;
      end
      CMD_NBSP: begin
        main_end = (idx == IDX_W'(NBSP_LEN - 1)) && (rep == REPS_W'(1));
        out_char = nbsp_char(idx);
      end
      CMD_BR: begin
        main_end = (idx == IDX_W'(BR_LEN - 1));
        out_char = br_char(idx);
      end
      default: begin
        main_end = 1'b1;
        out_char = cmd.ch;
      end
    endcase
    if (gt_phase) begin
      out_char = CH_GT;
    end
  end

  assign final_char  = gt_phase || (main_end && !cmd.add_gt);
  assign out_valid   = busy;
  assign last_of_run = final_char;
  assign text_done   = final_char && cmd.last;
  assign take        = out_valid && out_ready;
  assign pop         = q_not_empty && (!busy || (take && final_char));

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= '0;
      rep      <= '0;
      gt_phase <= 1'b0;
    end else if (pop) begin
      busy     <= 1'b1;
      idx      <= '0;
      rep      <= q_head.reps;
      gt_phase <= 1'b0;
    end else if (take) begin
      if (final_char) begin
        busy <= 1'b0;
      end else if (main_end) begin
        gt_phase <= 1'b1;
      end else if (cmd.kind == CMD_NBSP && idx == IDX_W'(NBSP_LEN - 1)) begin
        idx <= '0;
        rep <= rep - REPS_W'(1);
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/wtm_checker.sv */
// Port-level checker for the tab expander, bound to the top level.
// Depends on whitespace_to_markup_tab_expander.
`timescale 1ns / 1ps
`default_nettype none

module wtm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [20:0] out_char,
  input wire logic        last_of_run,
  input wire logic        text_done
);

  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char))
    else $error("output transaction dropped or changed while stalled");

  ap_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_done |-> last_of_run)
    else $error("text_done without last_of_run");

  ap_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("run ended without last_of_run");

  ap_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind whitespace_to_markup_tab_expander wtm_checker u_wtm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_char   (out_char),
  .last_of_run(last_of_run),
  .text_done  (text_done)
);

`default_nettype wire

/* test/testbench.sv */
// Testbench for whitespace_to_markup_tab_expander: random and directed character streams.
// Predicts the expanded markup per input character and checks every output transaction.
// Depends on wtm_pkg and the whitespace_to_markup_tab_expander RTL.
`timescale 1ns / 1ps

module testbench;
  import wtm_pkg::*;

  localparam int TAB_STOP       = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_CHARS   = 320;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              eot;
    int                gap;
  } text_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              done;
  } glyph_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [CHAR_W-1:0] char_code   = '0;
  logic              end_of_text = 1'b0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              last_of_run;
  logic              text_done;

  text_item_t pending_chars[$];
  glyph_t     markup_q[$];

  logic tag_open = 1'b0;
  int   tab_col  = 0;

  int   src_mode     = 1;
  int   sink_mode    = 1;
  int   gap_count    = 0;
  int   stall_count  = 0;
  int   results_seen = 0;
  int   fail_count   = 0;
  int   idle_cycles  = 0;
  int   stall;
  glyph_t want;

  whitespace_to_markup_tab_expander #(
    .TAB_STOP(TAB_STOP)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .last_of_run(last_of_run),
    .text_done  (text_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_wait(input int mode);
    int w;
    case (mode)
      0:       w = 0;
      1:       w = $urandom_range(0, 17);
      default: w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 0;
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] draw_char();
    int                sel;
    logic [CHAR_W-1:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 40)      c = CHAR_W'($urandom_range(33, 126));
    else if (sel < 55) c = CH_SPACE;
    else if (sel < 65) c = CH_TAB;
    else if (sel < 72) c = CH_NL;
    else if (sel < 80) c = CH_LT;
    else if (sel < 86) c = CH_GT;
    else               c = CHAR_W'($urandom_range(0, 21'h1FFFFF));
    return c;
  endfunction

  task automatic add_char(input logic [CHAR_W-1:0] ch, input logic eot);
    text_item_t it;
    it.ch  = ch;
    it.eot = eot;
    it.gap = draw_wait(src_mode);
    pending_chars.push_back(it);
  endtask

  task automatic push_glyph(input logic [CHAR_W-1:0] ch);
    glyph_t g;
    g.ch   = ch;
    g.last = 1'b0;
    g.done = 1'b0;
    markup_q.push_back(g);
  endtask

  task automatic push_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) push_glyph({13'd0, s[k]});
  endtask

  task automatic step_column();
    tab_col = (tab_col + 1) % TAB_STOP;
  endtask

  task automatic expand_char(input logic [CHAR_W-1:0] ch, input logic eot);
    int     k;
    glyph_t g;
    if (tag_open) begin
      push_glyph(ch);
      step_column();
      if (ch == CH_GT) tag_open = 1'b0;
    end else if (ch == CH_LT) begin
      push_glyph(ch);
      step_column();
      tag_open = 1'b1;
    end else if (ch == CH_SPACE) begin
      push_text("&nbsp;");
      step_column();
    end else if (ch == CH_NL) begin
      push_text("<br>");
      tab_col = 0;
    end else if (ch == CH_TAB) begin
      for (k = 0; k < TAB_STOP - tab_col; k++) push_text("&nbsp;");
      tab_col = 0;
    end else begin
      push_glyph(ch);
      step_column();
    end
    if (eot) begin
      if (tag_open) push_glyph(CH_GT);
      tag_open = 1'b0;
      tab_col  = 0;
    end
    g      = markup_q.pop_back();
    g.last = 1'b1;
    g.done = eot;
    markup_q.push_back(g);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      gap_count <= 0;
    end else begin
      if (in_valid && in_ready) expand_char(char_code, end_of_text);
      if (!in_valid || in_ready) begin
        if (pending_chars.size() == 0) begin
          in_valid <= 1'b0;
        end else if (gap_count < pending_chars[0].gap) begin
          in_valid  <= 1'b0;
          gap_count <= gap_count + 1;
        end else begin
          char_code   <= pending_chars[0].ch;
          end_of_text <= pending_chars[0].eot;
          in_valid    <= 1'b1;
          gap_count   <= 0;
          pending_chars.delete(0);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready   <= 1'b0;
      stall_count <= 0;
    end else if (out_valid && out_ready) begin
      if (markup_q.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected output: char=%h last=%b done=%b",
                   out_char, last_of_run, text_done);
        fail_count++;
      end else begin
        want = markup_q.pop_front();
        if (want.ch !== out_char || want.last !== last_of_run || want.done !== text_done) begin
          if (fail_count < MAX_REPORTS)
            $display("mismatch: expected char=%h last=%b done=%b, got char=%h last=%b done=%b",
                     want.ch, want.last, want.done, out_char, last_of_run, text_done);
          fail_count++;
        end
      end
      results_seen++;
      if (results_seen % 64 == 0) sink_mode = $urandom_range(0, 2);
      stall = draw_wait(sink_mode);
      out_ready   <= (stall == 0);
      stall_count <= stall;
    end else if (!out_ready) begin
      if (stall_count <= 1) out_ready <= 1'b1;
      stall_count <= stall_count - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int text_len;
    int i;

    add_char(21'h61, 1'b0);
    add_char(21'h1FFFFF, 1'b0);
    add_char(21'h000000, 1'b0);
    add_char(CH_SPACE, 1'b0);
    add_char(CH_TAB, 1'b0);
    add_char(CH_TAB, 1'b0);
    add_char(CH_NL, 1'b0);
    add_char(CH_GT, 1'b0);
    add_char(CH_LT, 1'b0);
    add_char(CH_SPACE, 1'b0);
    add_char(CH_TAB, 1'b0);
    add_char(CH_NL, 1'b0);
    add_char(21'h10FFFF, 1'b0);
    add_char(CH_GT, 1'b0);
    add_char(21'h78, 1'b0);
    add_char(CH_LT, 1'b1);
    add_char(CH_LT, 1'b0);
    add_char(21'h62, 1'b1);
    add_char(CH_TAB, 1'b1);
    add_char(CH_NL, 1'b1);
    add_char(CH_LT, 1'b0);
    add_char(CH_GT, 1'b1);

    while (pending_chars.size() < RANDOM_CHARS + 22) begin
      src_mode = $urandom_range(0, 2);
      text_len = $urandom_range(1, 24);
      for (i = 0; i < text_len; i++)
        add_char(draw_char(), (i == text_len - 1) && ($urandom_range(0, 5) != 0));
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || in_valid) @(posedge clk);
    while (markup_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/wtm_pkg.sv
design/wtm_front.sv
design/wtm_queue.sv
design/wtm_back.sv
design/whitespace_to_markup_tab_expander.sv
design/wtm_checker.sv
test/testbench.sv
